[hw/rtl/ihrc_pkg.sv]
package ihrc_pkg;

  localparam int unsigned ADDR_W       = 32;
  localparam int unsigned INDEX_W      = 6;
  localparam int unsigned SUM_W        = 16;
  localparam int unsigned MIN_HDR_LEN  = 20;
  localparam int unsigned LAST_HDR_IDX = 59;

  localparam logic [3:0]        IP_VERSION    = 4'd4;
  localparam logic [3:0]        MIN_IHL       = 4'd5;
  localparam logic [ADDR_W-1:0] BROADCAST     = '1;
  localparam logic [SUM_W-1:0]  SUM_ALL_ONES  = '1;

  localparam logic [INDEX_W-1:0] VER_IHL_IDX  = 6'd0;
  localparam logic [INDEX_W-1:0] TTL_IDX      = 6'd8;
  localparam logic [INDEX_W-1:0] DST_FIRST    = 6'd16;
  localparam logic [INDEX_W-1:0] DST_LAST     = 6'd19;

  typedef enum logic [2:0] {
    STATUS_ACCEPT       = 3'd0,
    STATUS_TTL_ZERO     = 3'd1,
    STATUS_BAD_VERSION  = 3'd2,
    STATUS_SHORT_HEADER = 3'd3,
    STATUS_WRONG_DEST   = 3'd4,
    STATUS_BAD_CHECKSUM = 3'd5
  } status_t;

  // Checks in priority order; first failure wins.
  function automatic status_t judge(
    input logic              ttl_zero,
    input logic [7:0]        ver_ihl,
    input logic [ADDR_W-1:0] dst,
    input logic [ADDR_W-1:0] local_addr,
    input logic [SUM_W-1:0]  sum
  );
    status_t res;
    priority if (ttl_zero) begin
      res = STATUS_TTL_ZERO;
    end else if (ver_ihl[7:4] != IP_VERSION) begin
      res = STATUS_BAD_VERSION;
    end else if (ver_ihl[3:0] < MIN_IHL) begin
      res = STATUS_SHORT_HEADER;
    end else if (dst != local_addr && dst != BROADCAST) begin
      res = STATUS_WRONG_DEST;
    end else if (sum != SUM_ALL_ONES) begin
      res = STATUS_BAD_CHECKSUM;
    end else begin
      res = STATUS_ACCEPT;
    end
    return res;
  endfunction

endpackage

[hw/rtl/ipv4_header_receive_checker_top.sv]
// IPv4 header receive checker. Packet bytes enter in wire order on the
// in_valid/in_ready channel, first_byte set on byte 0 of each packet. Once
// max(20, 4*IHL) header bytes have been taken, one status transfer leaves on
// the out_valid/out_ready channel: 0 accept, 1 TTL zero, 2 version not 4,
// 3 IHL below 5, 4 destination neither local_address nor 255.255.255.255,
// 5 header checksum bad; the first failing check is reported. Payload bytes
// and bytes outside a packet produce nothing, and a first_byte mid-header
// drops the header in progress. Short logic sits between the byte input and
// the status register, so the status is valid the cycle after the last
// header byte transfer, and a byte is taken every cycle while the status
// register is empty or being drained. Write local_address
// over the cfg channel only while no packet is in flight.
module ipv4_header_receive_checker_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 data_byte,
  input  logic                       first_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 status,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ihrc_pkg::ADDR_W-1:0] cfg_data
);
  import ihrc_pkg::*;

  logic [ADDR_W-1:0]  local_address;
  logic [INDEX_W-1:0] byte_index;
  logic [7:0]         version_ihl;
  logic               ttl_zero_flag;
  logic [ADDR_W-1:0]  destination_shift;
  logic [SUM_W-1:0]   ones_sum;
  logic [7:0]         high_byte_hold;
  logic               verdict_given;
  status_t            verdict;

  logic [INDEX_W-1:0] byte_index_next;
  logic [7:0]         version_ihl_next;
  logic               ttl_zero_flag_next;
  logic [ADDR_W-1:0]  destination_shift_next;
  logic [SUM_W-1:0]   ones_sum_next;
  logic [7:0]         high_byte_hold_next;

  logic [INDEX_W-1:0] base_index;
  logic [7:0]         base_ver_ihl;
  logic               base_ttl;
  logic [ADDR_W-1:0]  base_dst;
  logic [SUM_W-1:0]   base_sum;
  logic [7:0]         base_hold;
  logic [SUM_W:0]     word_sum;
  logic [INDEX_W:0]   hdr_len;
  logic [INDEX_W:0]   seen;
  logic               in_fire;
  logic               active;
  logic               done;

  assign cfg_ready = 1'b1;
  assign in_ready  = ~out_valid | out_ready;
  assign in_fire   = in_valid & in_ready;
  assign active    = first_byte | ~verdict_given;
  assign status    = verdict;

  always_comb begin
    // A start byte sees a cleared header context.
    base_index   = first_byte ? '0 : byte_index;
    base_ver_ihl = first_byte ? '0 : version_ihl;
    base_ttl     = first_byte ? 1'b0 : ttl_zero_flag;
    base_dst     = first_byte ? '0 : destination_shift;
    base_sum     = first_byte ? '0 : ones_sum;
    base_hold    = first_byte ? '0 : high_byte_hold;

    version_ihl_next   = (base_index == VER_IHL_IDX) ? data_byte : base_ver_ihl;
    ttl_zero_flag_next = (base_index == TTL_IDX) ? (data_byte == 8'd0) : base_ttl;
    destination_shift_next = base_dst;
    if (base_index >= DST_FIRST && base_index <= DST_LAST) begin
      destination_shift_next = {base_dst[ADDR_W-9:0], data_byte};
    end

    // End-around carry: low half + carry cannot overflow again.
    word_sum = {1'b0, base_sum} + {1'b0, base_hold, data_byte};
    if (base_index[0]) begin
      high_byte_hold_next = base_hold;
      ones_sum_next       = word_sum[SUM_W-1:0] + SUM_W'(word_sum[SUM_W]);
    end else begin
      high_byte_hold_next = data_byte;
      ones_sum_next       = base_sum;
    end

    byte_index_next = base_index + 1'b1;
    hdr_len = {1'b0, version_ihl_next[3:0], 2'b00};
    if (hdr_len < (INDEX_W+1)'(MIN_HDR_LEN)) begin
      hdr_len = (INDEX_W+1)'(MIN_HDR_LEN);
    end
    seen = {1'b0, base_index} + 1'b1;
    done = active & (seen >= hdr_len);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      local_address     <= '0;
      byte_index        <= '0;
      version_ihl       <= '0;
      ttl_zero_flag     <= 1'b0;
      destination_shift <= '0;
      ones_sum          <= '0;
      high_byte_hold    <= '0;
      verdict_given     <= 1'b1;
      out_valid         <= 1'b0;
      verdict           <= STATUS_ACCEPT;
    end else begin
      if (cfg_valid && cfg_ready) begin
        local_address <= cfg_data;
      end
      // A new verdict may land in the same cycle the old one is drained.
      if (in_fire && done) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_fire && active) begin
        byte_index        <= byte_index_next;
        version_ihl       <= version_ihl_next;
        ttl_zero_flag     <= ttl_zero_flag_next;
        destination_shift <= destination_shift_next;
        ones_sum          <= ones_sum_next;
        high_byte_hold    <= high_byte_hold_next;
        verdict_given     <= done;
        if (done) begin
          verdict   <= judge(ttl_zero_flag_next, version_ihl_next,
                             destination_shift_next, local_address, ones_sum_next);
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_verdict_sets_output: assert property (@(posedge clk) disable iff (rst)
    (in_fire && done) |=> (out_valid && verdict_given))
    else $error("verdict not registered after header end");

  a_header_index_bound: assert property (@(posedge clk) disable iff (rst)
    !verdict_given |-> (byte_index <= INDEX_W'(LAST_HDR_IDX)))
    else $error("byte index past longest header");

  a_idle_byte_silent: assert property (@(posedge clk) disable iff (rst)
    (in_fire && verdict_given && !first_byte && !out_valid) |=> !out_valid)
    else $error("result from byte outside a header");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status <= STATUS_BAD_CHECKSUM))
    else $error("status code out of range");
`endif

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import ihrc_pkg::*;

  // Header verdict predictor plus the store of verdicts still owed by the block.
  class verdict_board;
    logic [31:0]  local_addr;
    logic [5:0]   hdr_pos;
    logic [7:0]   ver_ihl;
    logic         ttl_zero;
    logic [31:0]  dst_addr;
    logic [15:0]  hdr_sum;
    logic [7:0]   hi_byte;
    logic         idle;
    status_t      verdict_q[$];
    int           errors;
    int           issued;
    int           checked;
    int           seen[6];

    function new();
      local_addr = '0;
      hdr_pos    = '0;
      ver_ihl    = '0;
      ttl_zero   = 1'b0;
      dst_addr   = '0;
      hdr_sum    = '0;
      hi_byte    = '0;
      idle       = 1'b1;
      errors     = 0;
      issued     = 0;
      checked    = 0;
      foreach (seen[i]) seen[i] = 0;
    endfunction

    function status_t verdict();
      if (ttl_zero) return STATUS_TTL_ZERO;
      if (ver_ihl[7:4] != IP_VERSION) return STATUS_BAD_VERSION;
      if (ver_ihl[3:0] < MIN_IHL) return STATUS_SHORT_HEADER;
      if (dst_addr != local_addr && dst_addr != BROADCAST) return STATUS_WRONG_DEST;
      if (hdr_sum != SUM_ALL_ONES) return STATUS_BAD_CHECKSUM;
      return STATUS_ACCEPT;
    endfunction

    // Called on every accepted byte transfer.
    function void take_byte(input logic [7:0] d, input logic f);
      logic [16:0] acc;
      int          hdr_len;
      if (f) begin
        hdr_pos  = '0;
        ver_ihl  = '0;
        ttl_zero = 1'b0;
        dst_addr = '0;
        hdr_sum  = '0;
        hi_byte  = '0;
        idle     = 1'b0;
      end else if (idle) begin
        return;
      end
      if (hdr_pos == VER_IHL_IDX) ver_ihl = d;
      if (hdr_pos == TTL_IDX) ttl_zero = (d == 8'h00);
      if (hdr_pos >= DST_FIRST && hdr_pos <= DST_LAST) dst_addr = {dst_addr[23:0], d};
      if (!hdr_pos[0]) begin
        hi_byte = d;
      end else begin
        // ones' complement add, end-around carry
        acc = {1'b0, hdr_sum} + {1'b0, hi_byte, d};
        if (acc[16]) acc = {1'b0, acc[15:0]} + 17'd1;
        hdr_sum = acc[15:0];
      end
      hdr_pos = hdr_pos + 6'd1;
      hdr_len = (ver_ihl[3:0] < MIN_IHL) ? int'(MIN_HDR_LEN) : 4 * int'(ver_ihl[3:0]);
      if (int'(hdr_pos) >= hdr_len) begin
        idle = 1'b1;
        verdict_q.push_back(verdict());
        issued++;
      end
    endfunction

    function void check_status(input logic [2:0] got);
      status_t want;
      if (verdict_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: status %0d arrived with no verdict pending", got);
        return;
      end
      want = verdict_q.pop_front();
      checked++;
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: verdict %0d: expected status %0d, got %0d", checked, want, got);
        end
      end else begin
        seen[int'(want)]++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  verdict_board board = new();
  logic [7:0]   hdr[$];
  bit           tx_calm;
  bit           rx_calm;
  int           rx_hold;
  int           bytes_sent;
  int           settings_used;

  ipv4_header_receive_checker_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .first_byte (first_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // All driver tasks enter and leave at a falling edge.
  task automatic send_byte(input logic [7:0] d, input logic f);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= d;
    first_byte <= f;
    do @(posedge clk); while (!in_ready);
    board.take_byte(d, f);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_packet(input int upto, input int tail);
    for (int i = 0; i < upto; i++) send_byte(hdr[i], i == 0);
    repeat (tail) send_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // Sender goes quiet until every owed verdict is in, then lets the pipe settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_local(input logic [31:0] addr);
    cfg_valid <= 1'b1;
    cfg_data  <= addr;
    do @(posedge clk); while (!cfg_ready);
    board.local_addr = addr;
    settings_used++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Fills hdr with a header of random content; checksum is made valid unless told otherwise.
  function automatic void make_header(input logic [3:0] ver, input logic [3:0] ihl,
                                      input logic [7:0] ttl, input logic [31:0] dst,
                                      input bit good_sum);
    int          n;
    logic [16:0] acc;
    logic [15:0] csum;
    n = (ihl < MIN_IHL) ? int'(MIN_HDR_LEN) : 4 * int'(ihl);
    hdr.delete();
    for (int i = 0; i < n; i++) hdr.push_back(8'($urandom_range(0, 255)));
    hdr[0]  = {ver, ihl};
    hdr[8]  = ttl;
    for (int i = 0; i < 4; i++) hdr[16 + i] = dst[31 - 8 * i -: 8];
    hdr[10] = 8'h00;
    hdr[11] = 8'h00;
    acc = '0;
    for (int i = 0; i < n; i += 2) begin
      acc = {1'b0, acc[15:0]} + {1'b0, hdr[i], hdr[i + 1]};
      if (acc[16]) acc = {1'b0, acc[15:0]} + 17'd1;
    end
    csum    = ~acc[15:0];
    hdr[10] = csum[15:8];
    hdr[11] = csum[7:0];
    if (!good_sum) hdr[10 + $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
  endfunction

  task automatic random_packet();
    logic [3:0]  ver;
    logic [3:0]  ihl;
    logic [7:0]  ttl;
    logic [31:0] dst;
    bit          good;
    int          n;
    int          cut;
    int          tail;
    int          r;
    ver = ($urandom_range(0, 11) == 0) ? 4'($urandom_range(0, 15)) : IP_VERSION;
    r   = $urandom_range(0, 99);
    ihl = (r < 8) ? 4'($urandom_range(0, 4)) :
          (r < 70) ? MIN_IHL : 4'($urandom_range(6, 15));
    ttl = ($urandom_range(0, 11) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
    r   = $urandom_range(0, 99);
    dst = (r < 45) ? board.local_addr :
          (r < 65) ? BROADCAST :
          (r < 80) ? board.local_addr ^ (32'd1 << $urandom_range(0, 31)) : $urandom;
    good = ($urandom_range(0, 7) != 0);
    make_header(ver, ihl, ttl, dst, good);
    n    = hdr.size();
    // occasionally cut short so the next packet restarts mid-header
    cut  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, n - 1) : n;
    tail = (cut < n) ? 0 : $urandom_range(0, 6);
    send_packet(cut, tail);
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 8)) begin
      send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    end
  endtask

  // Result side: random ready gaps, plus one long hold-off on request.
  initial begin
    int gap;
    out_ready = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 7) == 0) rx_calm = !rx_calm;
      gap = rx_calm ? 0 : $urandom_range(0, 14);
      if (rx_hold > 0) begin
        gap     = rx_hold;
        rx_hold = 0;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      board.check_status(status);
      @(negedge clk);
    end
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [31:0] addr_list[5];
    logic [31:0] home;
    int          byte_goal;
    int          verdict_goal;
    in_valid   = 1'b0;
    data_byte  = '0;
    first_byte = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed
    home    = 32'hC0A8_0A01;
    tx_calm = 1'b0;
    write_local(home);
    send_byte(8'hFF, 1'b0);                      // before any packet: ignored
    send_byte(8'h00, 1'b0);
    make_header(4'd4, 4'd5, 8'd64, home, 1'b1);
    send_packet(20, 3);                          // accept, payload ignored
    make_header(4'd4, 4'd5, 8'hFF, BROADCAST, 1'b1);
    send_packet(20, 0);
    make_header(4'd6, 4'd5, 8'h00, home, 1'b0);  // ttl wins over version
    send_packet(20, 0);
    make_header(4'hF, 4'd5, 8'd1, home, 1'b1);
    send_packet(20, 0);
    make_header(4'd0, 4'd0, 8'd9, 32'h0, 1'b0);
    send_packet(20, 0);
    make_header(4'd4, 4'd0, 8'd9, home, 1'b1);   // IHL 0 treated as 20 bytes
    send_packet(20, 0);
    make_header(4'd4, 4'd4, 8'd9, ~home, 1'b0);
    send_packet(20, 0);
    make_header(4'd4, 4'hF, 8'd128, home, 1'b1); // longest header
    send_packet(60, 2);
    make_header(4'd4, 4'd5, 8'd30, home ^ 32'h1, 1'b1);
    send_packet(20, 0);
    make_header(4'd4, 4'd5, 8'd30, home, 1'b0);
    send_packet(20, 0);
    make_header(4'd4, 4'd7, 8'd30, home, 1'b1);
    send_packet(11, 0);                          // dropped by restart below
    make_header(4'd4, 4'd5, 8'd30, BROADCAST, 1'b1);
    send_packet(20, 0);
    send_byte(8'h45, 1'b0);                      // after verdict: ignored
    wait_drained();

    // random phases, extreme addresses included
    addr_list[0] = 32'h0000_0000;
    addr_list[1] = 32'hFFFF_FFFF;
    addr_list[2] = $urandom;
    addr_list[3] = $urandom;
    addr_list[4] = home;
    for (int p = 0; p < 5; p++) begin
      write_local(addr_list[p]);
      if (p == 2) begin
        // receiver stalls long while the sender keeps pushing minimal headers
        rx_hold = 300;
        tx_calm = 1'b1;
        repeat (6) begin
          make_header(IP_VERSION, MIN_IHL, 8'd32, board.local_addr, 1'b1);
          send_packet(20, 0);
        end
      end
      byte_goal    = bytes_sent + 60;
      verdict_goal = board.issued + 2;
      while (bytes_sent < byte_goal || board.issued < verdict_goal) begin
        tx_calm = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 99) < 8) noise_burst();
        else random_packet();
        if ($urandom_range(0, 29) == 0) wait_drained();
      end
      // close on a full header so the block is idle for the next address write
      make_header(IP_VERSION, MIN_IHL, 8'd5, board.local_addr, 1'b1);
      send_packet(20, $urandom_range(0, 4));
      wait_drained();
    end

    repeat (10) @(posedge clk);
    $display("Covered %0d bytes, %0d header verdicts, %0d local address settings",
             bytes_sent, board.checked, settings_used);
    $display("Verdicts: accept %0d, ttl %0d, version %0d, short %0d, dest %0d, checksum %0d",
             board.seen[0], board.seen[1], board.seen[2], board.seen[3], board.seen[4],
             board.seen[5]);
    if (board.errors == 0 && board.verdict_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[ipv4_header_receive_checker_top.f]
hw/rtl/ihrc_pkg.sv
hw/rtl/ipv4_header_receive_checker_top.sv
test/tb_top.sv
